// ===== sv/wsd_pkg.sv =====
// Shared types, codes and constants for the WebSocket frame deframer.
package wsd_pkg;

	localparam int LENGTH_WIDTH_DEF = 64;

	// parse phases
	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_LEN16   = 3'd1,
		PH_LEN64   = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_ERROR   = 3'd5
	} phase_t;

	// frame events
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_MESSAGE = 3'd1,
		EV_CLOSE   = 3'd2,
		EV_PONG    = 3'd3,
		EV_ERROR   = 3'd4
	} event_t;

	// opcodes
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;

	// 7-bit length codes that select an extended length field
	localparam logic [6:0] LEN_CODE_64 = 7'd127;
	localparam logic [6:0] LEN_CODE_16 = 7'd126;

	// index of the last byte of each multi-byte field
	localparam logic [2:0] LEN16_LAST = 3'd1;
	localparam logic [2:0] LEN64_LAST = 3'd7;
	localparam logic [2:0] MASK_LAST  = 3'd3;

	typedef struct packed {
		logic       valid;
		logic [7:0] payload_byte;
		logic       has_byte;
		logic       frame_end;
		logic       final_fragment;
		logic [3:0] frame_opcode;
		logic       message_kind;
		event_t     event_res;
	} result_t;

endpackage

// ===== sv/wsd_parser.sv =====
// Frame parser: parse state registers and the per-byte next-state and result logic.
module wsd_parser import wsd_pkg::*; #(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	output result_t    res
);

	phase_t                  phase_q, phase_d;
	logic [2:0]              bif_q, bif_d;
	logic [7:0]              hdr_q, hdr_d;
	logic [LENGTH_WIDTH-1:0] rem_q, rem_d;
	logic                    ovf_q, ovf_d;
	logic [31:0]             key_q, key_d;
	logic [1:0]              idx_q, idx_d;
	logic                    kind_q, kind_d;

	logic                    err;
	logic                    finish;
	logic                    fin_has;
	logic [7:0]              data_out;
	logic [LENGTH_WIDTH+7:0] shifted;
	logic [2:0]              last_idx;
	logic [7:0]              key_byte;

	assign shifted  = {rem_q, data_byte};
	assign key_byte = key_q[{~idx_q, 3'b000} +: 8];

	always_comb begin
		phase_d  = phase_q;
		bif_d    = bif_q;
		hdr_d    = hdr_q;
		rem_d    = rem_q;
		ovf_d    = ovf_q;
		key_d    = key_q;
		idx_d    = idx_q;
		kind_d   = kind_q;
		err      = 1'b0;
		finish   = 1'b0;
		fin_has  = 1'b0;
		data_out = 8'h00;
		last_idx = LEN64_LAST;
		res      = '0;

		if (step) begin
			case (phase_q)
				PH_HEADER: begin
					if (bif_q == 3'd0) begin
						hdr_d = data_byte;
						bif_d = 3'd1;
					end else begin
						bif_d = 3'd0;
						ovf_d = 1'b0;
						if (!data_byte[7]) begin
							err = 1'b1;
						end else if (data_byte[6:0] == LEN_CODE_64) begin
							phase_d = PH_LEN64;
							rem_d   = '0;
						end else if (data_byte[6:0] == LEN_CODE_16) begin
							phase_d = PH_LEN16;
							rem_d   = '0;
						end else begin
							phase_d = PH_MASK;
							rem_d   = LENGTH_WIDTH'(data_byte[6:0]);
						end
					end
				end
				PH_LEN16, PH_LEN64: begin
					last_idx = (phase_q == PH_LEN16) ? LEN16_LAST : LEN64_LAST;
					rem_d    = shifted[LENGTH_WIDTH-1:0];
					// bits pushed past the length register make the length too wide
					ovf_d    = ovf_q | (|shifted[LENGTH_WIDTH+7:LENGTH_WIDTH]);
					if (bif_q < last_idx) begin
						bif_d = bif_q + 3'd1;
					end else begin
						bif_d = 3'd0;
						if (ovf_d) begin
							err = 1'b1;
						end else begin
							phase_d = PH_MASK;
						end
					end
				end
				PH_MASK: begin
					key_d = {key_q[23:0], data_byte};
					if (bif_q < MASK_LAST) begin
						bif_d = bif_q + 3'd1;
					end else begin
						bif_d = 3'd0;
						idx_d = 2'd0;
						if (rem_q == '0) begin
							finish = 1'b1;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					data_out = data_byte ^ key_byte;
					idx_d    = idx_q + 2'd1;
					rem_d    = rem_q - LENGTH_WIDTH'(1);
					if (rem_q == LENGTH_WIDTH'(1)) begin
						finish  = 1'b1;
						fin_has = 1'b1;
					end else begin
						res.valid     = 1'b1;
						res.has_byte  = 1'b1;
						res.event_res = EV_NONE;
					end
				end
				default: begin
					// error phase: byte dropped
				end
			endcase

			if (err) begin
				phase_d       = PH_ERROR;
				res.valid     = 1'b1;
				res.event_res = EV_ERROR;
			end

			if (finish) begin
				phase_d       = PH_HEADER;
				bif_d         = 3'd0;
				res.valid     = 1'b1;
				res.has_byte  = fin_has;
				res.frame_end = 1'b1;
				case (hdr_q[3:0])
					OP_CONT: begin
						res.event_res = hdr_q[7] ? EV_MESSAGE : EV_NONE;
					end
					OP_TEXT: begin
						kind_d        = 1'b0;
						res.event_res = hdr_q[7] ? EV_MESSAGE : EV_NONE;
					end
					OP_BINARY: begin
						kind_d        = 1'b1;
						res.event_res = hdr_q[7] ? EV_MESSAGE : EV_NONE;
					end
					OP_CLOSE: res.event_res = EV_CLOSE;
					OP_PING:  res.event_res = EV_PONG;
					default: begin
						res.event_res = EV_ERROR;
						phase_d       = PH_ERROR;
					end
				endcase
			end
		end

		res.payload_byte   = res.has_byte ? data_out : 8'h00;
		res.final_fragment = hdr_d[7];
		res.frame_opcode   = hdr_d[3:0];
		res.message_kind   = kind_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			bif_q   <= 3'd0;
			hdr_q   <= 8'h00;
			rem_q   <= '0;
			ovf_q   <= 1'b0;
			key_q   <= 32'h0;
			idx_q   <= 2'd0;
			kind_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			bif_q   <= bif_d;
			hdr_q   <= hdr_d;
			rem_q   <= rem_d;
			ovf_q   <= ovf_d;
			key_q   <= key_d;
			idx_q   <= idx_d;
			kind_q  <= kind_d;
		end
	end

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("left error phase before reset");

	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |-> !res.valid)
		else $error("result produced in error phase");

	a_payload_emits: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_PAYLOAD |-> res.valid && res.has_byte)
		else $error("payload byte produced no data result");

	a_bare_is_error: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.has_byte && !res.frame_end |-> res.event_res == EV_ERROR)
		else $error("empty result that is neither frame end nor error");

endmodule

// ===== sv/websocket_frame_deframer_core.sv =====
// Top level of the WebSocket frame deframer: input register, parser and result register.
//
// Channel  Direction  Handshake                    Payload
// stream   in         stream_valid / stream_stall  stream_byte[7:0]
// result   out        result_valid / result_stall  payload_byte, has_byte, frame_end,
//                                                  final_fragment, frame_opcode,
//                                                  message_kind, event_res
//
// One byte per cycle sustained while the result side does not stall. A byte lands in the
// input register, goes through the parser logic when the parser steps and its result (if
// any) is loaded into the result register at that edge, so the result transaction follows
// the stream transaction through the input register and the result register.
// arst_n clears the parse state, the input register valid and the result valid.
// A stall on the result side holds the parser and the input register; the stream side
// stalls only while the input register is full and cannot move on.
// Header, length and mask bytes that end nothing give no result transaction.
module websocket_frame_deframer_core import wsd_pkg::*; #(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       stream_valid,
	output logic       stream_stall,
	input  logic [7:0] stream_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] payload_byte,
	output logic       has_byte,
	output logic       frame_end,
	output logic       final_fragment,
	output logic [3:0] frame_opcode,
	output logic       message_kind,
	output logic [2:0] event_res
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       step;
	result_t    res;
	result_t    res_s2;
	logic       valid_s2;

	// result slot is free, or is being taken at this edge
	assign advance      = !(valid_s2 && result_stall);
	assign step         = valid_s1 && advance;
	assign stream_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream_valid && !stream_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream_valid && !stream_stall) begin
			byte_s1 <= stream_byte;
		end
	end

	wsd_parser #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result_valid   = valid_s2;
	assign payload_byte   = res_s2.payload_byte;
	assign has_byte       = res_s2.has_byte;
	assign frame_end      = res_s2.frame_end;
	assign final_fragment = res_s2.final_fragment;
	assign frame_opcode   = res_s2.frame_opcode;
	assign message_kind   = res_s2.message_kind;
	assign event_res      = res_s2.event_res;

	a_no_step_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_stall |-> !step)
		else $error("parser stepped while result held");

	a_data_only_with_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_byte |-> payload_byte == 8'h00)
		else $error("payload data without has_byte");

	a_mid_frame_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && has_byte && !frame_end |-> event_res == EV_NONE)
		else $error("event on a mid-frame payload byte");

endmodule
